/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for clk / rst_n clocked concurrent checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while in reset.
`define BMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define BMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bms_pkg.sv */
// ---------------------------------------------------------------------------
// bms_pkg
// Shared widths, defaults and command codes of the min-score buffer.
// ---------------------------------------------------------------------------
package bms_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int SCORE_W   = 32;
  localparam int ID_W      = 20;
  localparam int CMD_W     = 2;
  localparam int COUNT_W   = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

endpackage

/* rtl/bms_mem.sv */
// ---------------------------------------------------------------------------
// bms_mem
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module bms_mem
  import bms_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [SCORE_W-1:0] wr_score,
  input  logic [ID_W-1:0]    wr_id,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [SCORE_W-1:0] rd_score,
  output logic [ID_W-1:0]    rd_id
);

  logic [SCORE_W-1:0] score_mem [DEPTH];
  logic [ID_W-1:0]    id_mem    [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      score_mem[wr_addr] <= wr_score;
      id_mem[wr_addr]    <= wr_id;
    end
    if (rd_en) begin
      rd_score <= score_mem[rd_addr];
      rd_id    <= id_mem[rd_addr];
    end
  end

endmodule

/* rtl/bounded_min_score_buffer.sv */
// Append, clear, unused command, dropped insert, empty query: S_IDLE, S_FINISH, then the result registers.
// Query: scan of the filled entries, one entry read and compared per cycle, then S_FINISH.
// Full-buffer replace: scan for max entry, write, rescan for max, then S_FINISH.
// Handshake: one item at a time; in_ready returns as the result registers, which waits for out_ready.
// Reset: control state, fill count and tracked max cleared; entry memory is not cleared.
// ---------------------------------------------------------------------------
// bounded_min_score_buffer
// Keeps the DEPTH lowest (score, cluster id) pairs; answers min-score queries.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_min_score_buffer
  import bms_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [SCORE_W-1:0] in_score,
  input  logic [ID_W-1:0]    in_cluster_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_best_cluster_id,
  output logic               out_buffer_empty,
  output logic               out_inserted,
  output logic [COUNT_W-1:0] out_entry_count
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_EQ, S_WRITE_REP, S_SCAN_MAX, S_SCAN_MIN, S_FINISH
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   fill_r;
  logic [SCORE_W-1:0] max_r;
  logic [CNT_W-1:0]   scan_cnt_r;
  logic [CNT_W-1:0]   lim_r;
  logic               pv_r;
  logic [AW-1:0]      pidx_r;
  logic               found_r;
  logic [AW-1:0]      hit_idx_r;
  logic [SCORE_W-1:0] new_score_r;
  logic [ID_W-1:0]    new_id_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [ID_W-1:0]    res_id_r;
  logic               res_ins_r;
  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_empty_r;
  logic               out_ins_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               in_fire;
  logic               scanning;
  logic               issue;
  logic               scan_done;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [SCORE_W-1:0] wr_score;
  logic [ID_W-1:0]    wr_id;
  logic [SCORE_W-1:0] rd_score;
  logic [ID_W-1:0]    rd_id;
  logic               append;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign append    = in_fire && (in_command == CMD_INSERT) && (fill_r < DEPTH_C);
  assign scanning  = (state_r == S_SCAN_EQ) || (state_r == S_SCAN_MAX) ||
                     (state_r == S_SCAN_MIN);
  assign issue     = scanning && (scan_cnt_r < lim_r);
  assign scan_done = scanning && !issue && !pv_r;
  assign cnt_ext   = {{COUNT_W{1'b0}}, fill_r};

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = fill_r[AW-1:0];
    wr_score = in_score;
    wr_id    = in_cluster_id;
    if (append) begin
      wr_en = 1'b1;
    end else if (state_r == S_WRITE_REP) begin
      wr_en    = 1'b1;
      wr_addr  = hit_idx_r;
      wr_score = new_score_r;
      wr_id    = new_id_r;
    end
  end

  bms_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_score (wr_score),
    .wr_id    (wr_id),
    .rd_en    (issue),
    .rd_addr  (scan_cnt_r[AW-1:0]),
    .rd_score (rd_score),
    .rd_id    (rd_id)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      max_r       <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_FINISH the output register is handled by that state
      if (out_valid_r && out_ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      // read pipeline: data for pidx_r is present when pv_r is set
      pv_r <= issue;
      if (issue) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
        pidx_r     <= scan_cnt_r[AW-1:0];
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_id_r    <= '0;
            res_ins_r   <= append;
            new_score_r <= in_score;
            new_id_r    <= in_cluster_id;
            scan_cnt_r  <= '0;
            found_r     <= 1'b0;
            case (in_command)
              CMD_INSERT: begin
                if (fill_r < DEPTH_C) begin
                  fill_r  <= fill_r + 1'b1;
                  state_r <= S_FINISH;
                  if (in_score > max_r) begin
                    max_r <= in_score;
                  end
                end else if (in_score < max_r) begin
                  lim_r   <= DEPTH_C;
                  state_r <= S_SCAN_EQ;
                end else begin
                  state_r <= S_FINISH;
                end
              end
              CMD_CLEAR: begin
                fill_r  <= '0;
                max_r   <= '0;
                state_r <= S_FINISH;
              end
              CMD_QUERY: begin
                if (fill_r != '0) begin
                  lim_r   <= fill_r;
                  state_r <= S_SCAN_MIN;
                end else begin
                  state_r <= S_FINISH;
                end
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_SCAN_EQ: begin
          if (pv_r && !found_r && (rd_score == max_r)) begin
            found_r   <= 1'b1;
            hit_idx_r <= pidx_r;
          end
          if (scan_done) begin
            state_r <= found_r ? S_WRITE_REP : S_FINISH;
          end
        end
        S_WRITE_REP: begin
          res_ins_r  <= 1'b1;
          max_r      <= '0;
          scan_cnt_r <= '0;
          state_r    <= S_SCAN_MAX;
        end
        S_SCAN_MAX: begin
          if (pv_r && (rd_score > max_r)) begin
            max_r <= rd_score;
          end
          if (scan_done) begin
            state_r <= S_FINISH;
          end
        end
        S_SCAN_MIN: begin
          // first entry seeds the minimum; later ones win only when strictly lower
          if (pv_r && ((pidx_r == '0) || (rd_score < best_score_r))) begin
            best_score_r <= rd_score;
            res_id_r     <= rd_id;
          end
          if (scan_done) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_id_r    <= res_id_r;
            out_empty_r <= (fill_r == '0);
            out_ins_r   <= res_ins_r;
            out_count_r <= cnt_ext[COUNT_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_best_cluster_id = out_id_r;
  assign out_buffer_empty    = out_empty_r;
  assign out_inserted        = out_ins_r;
  assign out_entry_count     = out_count_r;

  `BMS_ASSERT(a_fill_bound, fill_r <= DEPTH_C, "fill count above depth")
  `BMS_ASSERT_NEXT(a_clear, in_fire && (in_command == CMD_CLEAR), (fill_r == '0) && (max_r == '0), "clear did not empty buffer")
  `BMS_ASSERT_NEXT(a_append, append, fill_r == $past(fill_r) + 1'b1, "append did not bump fill count")
  `BMS_ASSERT(a_busy_scan, scanning |-> !in_ready, "input taken during a scan")

endmodule
